>>> sv/page_frame_replacement_core_defines.svh
// ----------------------------------------------------------------------------
// page frame replacement core assertion macros
// concurrent assertion helpers, clocked on clk_i and disabled in reset
// ----------------------------------------------------------------------------
`ifndef PAGE_FRAME_REPLACEMENT_CORE_DEFINES_SVH
`define PAGE_FRAME_REPLACEMENT_CORE_DEFINES_SVH

// same-cycle implication
`define PFR_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pfr assertion failed");

// next-cycle implication
`define PFR_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pfr assertion failed");

`endif

>>> sv/pfr_pkg.sv
// ----------------------------------------------------------------------------
// pfr_pkg
// shared widths, codes and types of the page frame replacement core
// ----------------------------------------------------------------------------
`default_nettype none

package pfr_pkg;

  localparam int PidW      = 2;
  localparam int AddrW     = 16;
  localparam int RndW      = 31;
  localparam int TsW       = 32;
  localparam int CntW      = 32;
  localparam int SumW      = 48;
  localparam int FrameIdxW = 6;
  localparam int FifoW     = 6;
  localparam int FcW       = 7;
  localparam int PolW      = 2;
  localparam int CfgW      = 16;
  localparam int CfgIdxW   = 2;
  localparam int DivW      = 32;
  localparam int DivisorW  = 16;
  localparam int DivStepW  = 6;
  localparam int InDataW   = 56;
  localparam int OutDataW  = 160;

  localparam logic [CfgIdxW-1:0] RegPageSize  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegFrameCnt  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegPolicy    = 2'd2;

  localparam logic [PolW-1:0] PolLru    = 2'd0;
  localparam logic [PolW-1:0] PolRandom = 2'd1;
  localparam logic [PolW-1:0] PolFifo   = 2'd2;

  typedef struct packed {
    logic                valid;
    logic [PidW-1:0]     owner;
    logic [AddrW-1:0]    base;
    logic [TsW-1:0]      last_use;
    logic [TsW-1:0]      load_time;
  } pfr_entry_t;

  typedef struct packed {
    logic                start;
    logic [DivW-1:0]     dividend;
    logic [DivStepW-1:0] steps;
    logic [DivisorW-1:0] divisor;
  } pfr_div_req_t;

  typedef struct packed {
    logic                done;
    logic [DivisorW-1:0] rem;
  } pfr_div_rsp_t;

endpackage

`default_nettype wire

>>> sv/pfr_divider.sv
// ----------------------------------------------------------------------------
// pfr_divider
// restoring remainder unit, one quotient bit per cycle from the msb down
// ----------------------------------------------------------------------------
`default_nettype none

module pfr_divider
  import pfr_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire pfr_div_req_t req_i,
  output pfr_div_rsp_t      rsp_o
);

  logic                busy_q;
  logic                done_q;
  logic [DivStepW-1:0] cnt_q;
  logic [DivW-1:0]     dvd_q;
  logic [DivisorW-1:0] div_q;
  logic [DivisorW-1:0] rem_q;
  logic [DivisorW-1:0] rem_d;
  logic [DivisorW:0]   trial;
  logic [DivisorW:0]   diff;

  always_comb begin
    trial = {rem_q, dvd_q[DivW-1]};
    diff  = trial - {1'b0, div_q};
    if (trial >= {1'b0, div_q}) begin
      rem_d = diff[DivisorW-1:0];
    end else begin
      rem_d = trial[DivisorW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.steps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - DivStepW'(1);
        if (cnt_q == DivStepW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      div_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DivW-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

`default_nettype wire

>>> sv/page_frame_replacement_core.sv
// ----------------------------------------------------------------------------
// page_frame_replacement_core
// demand paging frame table with lru, random and fifo victim selection
// ----------------------------------------------------------------------------
// usage: one memory reference word enters on the s_axis channel and one
// result word leaves on the m_axis channel for each reference. the user must
// write registers page size, frame count and policy through cfg_we_i only
// while idle; the block itself does not enforce it.
// for each reference the core finds the page base and then the random pick
// on the shared remainder unit (16 steps for the page base, 31 for the
// random pick), scans the frame table one frame per cycle through the
// table's single read port, decides, and on a miss fills a free frame or
// first reads, evicts and accounts a victim before the fill; the result
// then enters the output register. s_axis_tready_o stays low from the
// acceptance of a reference until the core is idle again.
// after reset a pass over all MAX_FRAMES frames marks every frame free;
// no reference is taken during it. the result sits in an output register,
// so the next reference is accepted while m_axis waits; if the receiver
// still holds off when the next result is ready, the core waits for it.
// ----------------------------------------------------------------------------
`default_nettype none

`include "page_frame_replacement_core_defines.svh"

module page_frame_replacement_core
  import pfr_pkg::*;
#(
  parameter int MAX_FRAMES    = 64,
  parameter int NUM_PROCESSES = 4
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgW-1:0]     cfg_data_i,
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // process_id, virtual_address, random_value, zero pad
  input  wire logic [InDataW-1:0]  s_axis_tdata_i,
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  // hit, frame_index, evicted, victim_process, residency_added,
  // requester_faults, victim_evictions, victim_residency_total, zero pad
  output logic [OutDataW-1:0]      m_axis_tdata_o
);

  localparam int IdxW  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int FcntW = $clog2(MAX_FRAMES + 1);
  localparam int ProcW = (NUM_PROCESSES > 1) ? $clog2(NUM_PROCESSES) : 1;
  localparam int PadW  = OutDataW - (1 + FrameIdxW + 1 + PidW + TsW + CntW + CntW + SumW);

  localparam logic [3:0] StClear  = 4'd0;
  localparam logic [3:0] StIdle   = 4'd1;
  localparam logic [3:0] StPgGo   = 4'd2;
  localparam logic [3:0] StPgDiv  = 4'd3;
  localparam logic [3:0] StRndGo  = 4'd4;
  localparam logic [3:0] StRndDiv = 4'd5;
  localparam logic [3:0] StScan   = 4'd6;
  localparam logic [3:0] StScanEnd = 4'd7;
  localparam logic [3:0] StDecide = 4'd8;
  localparam logic [3:0] StVRead  = 4'd9;
  localparam logic [3:0] StVEvict = 4'd10;
  localparam logic [3:0] StVAcc   = 4'd11;
  localparam logic [3:0] StFill   = 4'd12;
  localparam logic [3:0] StDone   = 4'd13;

  function automatic logic [PidW-1:0] pid_mod(input logic [PidW-1:0] p);
    logic [PidW:0] v;
    v = {1'b0, p};
    for (int k = 0; k < 3; k++) begin
      if (int'(v) >= NUM_PROCESSES) begin
        v = v - (PidW+1)'(NUM_PROCESSES);
      end
    end
    return v[PidW-1:0];
  endfunction

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] a);
    return (a == '1) ? a : a + CntW'(1);
  endfunction

  function automatic logic [SumW-1:0] sat_add48(input logic [SumW-1:0] a,
                                                input logic [TsW-1:0]  b);
    logic [SumW:0] s;
    s = {1'b0, a} + (SumW+1)'(b);
    return s[SumW] ? '1 : s[SumW-1:0];
  endfunction

  // configuration
  logic [CfgW-1:0] page_size_q;
  logic [FcW-1:0]  frame_count_q;
  logic [PolW-1:0] policy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_size_q   <= CfgW'(10);
      frame_count_q <= FcW'(64);
      policy_q      <= PolLru;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegPageSize: page_size_q   <= cfg_data_i;
        RegFrameCnt: frame_count_q <= cfg_data_i[FcW-1:0];
        RegPolicy:   policy_q      <= cfg_data_i[PolW-1:0];
        default: ;
      endcase
    end
  end

  // control state
  logic [3:0]       state_q, state_d;
  logic [IdxW-1:0]  clr_idx_q;
  logic [FcntW-1:0] rd_idx_q;
  logic [FifoW-1:0] fifo_q;
  logic [CntW-1:0]  refcnt_q;
  logic             m_valid_q;
  logic [OutDataW-1:0] m_data_q;

  // per item
  logic [PidW-1:0]     pid_q;
  logic [AddrW-1:0]    addr_q;
  logic [RndW-1:0]     rnd_q;
  logic [DivisorW-1:0] psz_q;
  logic [FcntW-1:0]    fc_q;
  logic [PolW-1:0]     pol_q;
  logic [TsW-1:0]      now_q;
  logic [AddrW-1:0]    base_q;
  logic [DivisorW-1:0] rnd_rem_q;

  // scan tracking
  logic             proc_vld_q;
  logic [IdxW-1:0]  proc_idx_q;
  logic             found_q;
  logic [IdxW-1:0]  hit_idx_q;
  logic             free_any_q;
  logic [IdxW-1:0]  free_idx_q;
  logic             lru_any_q;
  logic [TsW-1:0]   lru_best_q;
  logic [IdxW-1:0]  lru_idx_q;

  // result
  logic             res_hit_q;
  logic [IdxW-1:0]  sel_q;
  logic             res_evicted_q;
  logic [PidW-1:0]  res_vproc_q;
  logic [TsW-1:0]   res_vres_q;
  logic [CntW-1:0]  res_vev_q;
  logic [SumW-1:0]  res_vtot_q;

  // per process counters
  logic [CntW-1:0] fault_cnt_q [NUM_PROCESSES];
  logic [CntW-1:0] evict_cnt_q [NUM_PROCESSES];
  logic [SumW-1:0] res_sum_q   [NUM_PROCESSES];

  // frame table
  pfr_entry_t      mem_q [MAX_FRAMES];
  pfr_entry_t      rd_data_q;
  logic            mem_we, mem_re;
  logic [IdxW-1:0] mem_waddr, mem_raddr;
  pfr_entry_t      mem_wdata;

  pfr_div_req_t div_req;
  pfr_div_rsp_t div_rsp;

  logic             in_acc;
  logic             out_free;
  logic [31:0]      fc_wide;
  logic [AddrW-1:0] hit_diff;
  logic             match;
  logic [IdxW-1:0]  victim_idx;
  logic [ProcW-1:0] pidx;
  logic [ProcW-1:0] vidx;
  logic [CntW-1:0]  new_evict;
  logic [SumW-1:0]  new_sum;

  assign s_axis_tready_o = (state_q == StIdle);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign pidx            = ProcW'(pid_q);
  assign vidx            = ProcW'(res_vproc_q);
  assign new_evict       = sat_inc(evict_cnt_q[vidx]);
  assign new_sum         = sat_add48(res_sum_q[vidx], res_vres_q);

  always_comb begin
    fc_wide = 32'(frame_count_q);
    if (fc_wide == 32'd0) begin
      fc_wide = 32'd1;
    end else if (fc_wide > 32'(MAX_FRAMES)) begin
      fc_wide = 32'(MAX_FRAMES);
    end
  end

  // hit test on the entry read in the previous cycle
  always_comb begin
    hit_diff = addr_q - rd_data_q.base;
    match = proc_vld_q && rd_data_q.valid && (rd_data_q.owner == pid_q) &&
            (addr_q >= rd_data_q.base) && (hit_diff < psz_q);
  end

  always_comb begin
    priority if (pol_q == PolRandom) begin
      victim_idx = IdxW'(rnd_rem_q);
    end else if (pol_q == PolFifo) begin
      if (fifo_q == '0 || 32'(fifo_q) > 32'(fc_q)) begin
        victim_idx = IdxW'(fc_q - FcntW'(1));
      end else begin
        victim_idx = IdxW'(fifo_q - FifoW'(1));
      end
    end else begin
      victim_idx = lru_idx_q;
    end
  end

  // remainder unit requests
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = {addr_q, {(DivW-AddrW){1'b0}}};
    div_req.steps    = DivStepW'(AddrW);
    div_req.divisor  = psz_q;
    unique case (state_q)
      StPgGo: div_req.start = 1'b1;
      StRndGo: begin
        div_req.start    = 1'b1;
        div_req.dividend = {rnd_q, {(DivW-RndW){1'b0}}};
        div_req.steps    = DivStepW'(RndW);
        div_req.divisor  = DivisorW'(fc_q);
      end
      default: ;
    endcase
  end

  pfr_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // frame table ports
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = proc_idx_q;
    mem_wdata = rd_data_q;
    mem_wdata.last_use = now_q;
    mem_re    = 1'b0;
    mem_raddr = rd_idx_q[IdxW-1:0];
    unique case (state_q)
      StClear: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx_q;
        mem_wdata = '0;
      end
      StScan: begin
        mem_re = 1'b1;
        mem_we = match;
      end
      StScanEnd: mem_we = match;
      StVRead: begin
        mem_re    = 1'b1;
        mem_raddr = sel_q;
      end
      StFill: begin
        mem_we              = 1'b1;
        mem_waddr           = sel_q;
        mem_wdata.valid     = 1'b1;
        mem_wdata.owner     = pid_q;
        mem_wdata.base      = base_q;
        mem_wdata.last_use  = now_q;
        mem_wdata.load_time = now_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem_q[mem_raddr];
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StClear:   if (clr_idx_q == IdxW'(MAX_FRAMES - 1)) state_d = StIdle;
      StIdle:    if (in_acc) state_d = StPgGo;
      StPgGo:    state_d = StPgDiv;
      StPgDiv:   if (div_rsp.done) state_d = StRndGo;
      StRndGo:   state_d = StRndDiv;
      StRndDiv:  if (div_rsp.done) state_d = StScan;
      StScan:    if (rd_idx_q == fc_q - FcntW'(1)) state_d = StScanEnd;
      StScanEnd: state_d = StDecide;
      StDecide: begin
        priority if (found_q) begin
          state_d = StDone;
        end else if (free_any_q) begin
          state_d = StFill;
        end else begin
          state_d = StVRead;
        end
      end
      StVRead:   state_d = StVEvict;
      StVEvict:  state_d = StVAcc;
      StVAcc:    state_d = StFill;
      StFill:    state_d = StDone;
      StDone:    if (out_free) state_d = StIdle;
      default:   state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StClear;
      clr_idx_q  <= '0;
      fifo_q     <= '0;
      refcnt_q   <= '0;
      m_valid_q  <= 1'b0;
      proc_vld_q <= 1'b0;
      for (int p = 0; p < NUM_PROCESSES; p++) begin
        fault_cnt_q[p] <= '0;
        evict_cnt_q[p] <= '0;
        res_sum_q[p]   <= '0;
      end
    end else begin
      state_q    <= state_d;
      proc_vld_q <= (state_q == StScan);
      if (state_q == StClear) begin
        clr_idx_q <= clr_idx_q + IdxW'(1);
      end
      if (state_q == StDone && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      if (state_q == StVAcc) begin
        evict_cnt_q[vidx] <= new_evict;
        res_sum_q[vidx]   <= new_sum;
      end
      if (state_q == StFill) begin
        fifo_q            <= FifoW'(sel_q);
        fault_cnt_q[pidx] <= sat_inc(fault_cnt_q[pidx]);
      end
      if (state_q == StDone && out_free) begin
        refcnt_q <= sat_inc(refcnt_q);
      end
    end
  end

  // item datapath
  always_ff @(posedge clk_i) begin
    proc_idx_q <= rd_idx_q[IdxW-1:0];
    if (in_acc) begin
      pid_q         <= pid_mod(s_axis_tdata_i[PidW-1:0]);
      addr_q        <= s_axis_tdata_i[PidW +: AddrW];
      rnd_q         <= s_axis_tdata_i[PidW+AddrW +: RndW];
      psz_q         <= (page_size_q == '0) ? DivisorW'(1) : page_size_q;
      fc_q          <= FcntW'(fc_wide);
      pol_q         <= policy_q;
      now_q         <= refcnt_q;
      found_q       <= 1'b0;
      free_any_q    <= 1'b0;
      lru_any_q     <= 1'b0;
      res_hit_q     <= 1'b0;
      res_evicted_q <= 1'b0;
      res_vproc_q   <= '0;
      res_vres_q    <= '0;
      res_vev_q     <= '0;
      res_vtot_q    <= '0;
    end
    if (state_q == StPgDiv && div_rsp.done) begin
      base_q <= addr_q - div_rsp.rem;
    end
    if (state_q == StRndDiv && div_rsp.done) begin
      rnd_rem_q <= div_rsp.rem;
      rd_idx_q  <= '0;
    end
    if (state_q == StScan) begin
      rd_idx_q <= rd_idx_q + FcntW'(1);
    end
    if (proc_vld_q) begin
      if (match && !found_q) begin
        found_q   <= 1'b1;
        hit_idx_q <= proc_idx_q;
      end
      if (!rd_data_q.valid) begin
        free_any_q <= 1'b1;
        free_idx_q <= proc_idx_q;
      end
      if (!lru_any_q || rd_data_q.last_use <= lru_best_q) begin
        lru_any_q  <= 1'b1;
        lru_best_q <= rd_data_q.last_use;
        lru_idx_q  <= proc_idx_q;
      end
    end
    if (state_q == StDecide) begin
      priority if (found_q) begin
        res_hit_q <= 1'b1;
        sel_q     <= hit_idx_q;
      end else if (free_any_q) begin
        sel_q <= free_idx_q;
      end else begin
        sel_q <= victim_idx;
      end
    end
    if (state_q == StVEvict) begin
      res_evicted_q <= 1'b1;
      res_vproc_q   <= rd_data_q.owner;
      res_vres_q    <= (now_q >= rd_data_q.load_time) ? now_q - rd_data_q.load_time : '0;
    end
    if (state_q == StVAcc) begin
      res_vev_q  <= new_evict;
      res_vtot_q <= new_sum;
    end
    if (state_q == StDone && out_free) begin
      m_data_q <= {{PadW{1'b0}}, res_vtot_q, res_vev_q, fault_cnt_q[pidx], res_vres_q,
                   res_vproc_q, res_evicted_q, FrameIdxW'(sel_q), res_hit_q};
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  `PFR_ASSERT_IMP(a_hit_no_evict, m_valid_q && m_data_q[0], !m_data_q[FrameIdxW+1])
  `PFR_ASSERT_NEXT(a_busy_after_accept, in_acc, !s_axis_tready_o)
  `PFR_ASSERT_IMP(a_port_clash, mem_we && mem_re, mem_waddr != mem_raddr)

endmodule

`default_nettype wire
